// ===== hw/rtl/skt_pkg.sv =====
// ---------------------------------------------------------------------------
// skt_pkg
// Shared types and constants for the sorted key table: request and result
// structures, request and status codes, controller states and datapath ops.
// ---------------------------------------------------------------------------
package skt_pkg;

  // table depth and derived widths
  localparam int DEPTH = 64;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // request type codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_DUMP   = 2'd2;

  // result status codes
  localparam logic [2:0] STS_DONE      = 3'd0;
  localparam logic [2:0] STS_FULL      = 3'd1;
  localparam logic [2:0] STS_NOT_FOUND = 3'd2;
  localparam logic [2:0] STS_LISTED    = 3'd3;
  localparam logic [2:0] STS_EMPTY     = 3'd4;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] req_key;
    logic [31:0]        req_payload;
  } skt_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] out_key;
    logic [31:0]        out_payload;
    logic               last;
  } skt_res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DUMP
  } skt_state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE,
    OP_EMPTY,
    OP_LIST,
    OP_NOP
  } skt_op_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    skt_op_t op;
  } skt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] req_type;
    logic       count_zero;
    logic       list_last;
  } skt_stat_t;

endpackage

// ===== hw/rtl/skt_ctrl.sv =====
// ---------------------------------------------------------------------------
// skt_ctrl
// Request sequencer: takes a request, runs the single table operation or
// steps a dump through every entry, and raises busy while at work.
// ---------------------------------------------------------------------------
module skt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  skt_pkg::skt_stat_t  stat,
  output skt_pkg::skt_cmd_t   cmd,
  output logic                busy
);
  import skt_pkg::*;

  skt_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd.load  = 1'b0;
    cmd.op    = OP_NONE;
    busy      = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        unique case (stat.req_type)
          REQ_INSERT: cmd.op = OP_INSERT;
          REQ_REMOVE: cmd.op = OP_REMOVE;
          REQ_DUMP: begin
            if (stat.count_zero) begin
              cmd.op = OP_EMPTY;
            end else begin
              cmd.op = OP_LIST;
              if (!stat.list_last) state_nxt = S_DUMP;
            end
          end
          default: cmd.op = OP_NOP;
        endcase
      end
      S_DUMP: begin
        cmd.op = OP_LIST;
        if (stat.list_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/skt_cells.sv =====
// ---------------------------------------------------------------------------
// skt_cells
// Datapath: a chain of key/payload cells kept in ascending key order. Every
// cell compares itself with the request key and shifts towards or away from
// its neighbour, so all cells take part in insert and remove. A dump rotates
// the valid part of the chain once round, emitting the head cell each cycle.
// ---------------------------------------------------------------------------
module skt_cells (
  input  logic                clk,
  input  logic                rst_n,
  input  skt_pkg::skt_req_t   in_req,
  input  skt_pkg::skt_cmd_t   cmd,
  output skt_pkg::skt_stat_t  stat,
  output skt_pkg::skt_res_t   out_res,
  output logic                out_valid
);
  import skt_pkg::*;

  logic signed [31:0] key_r [DEPTH];
  logic        [31:0] pay_r [DEPTH];
  logic signed [31:0] key_nxt [DEPTH];
  logic        [31:0] pay_nxt [DEPTH];
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   cnt_m1;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  skt_req_t           req_r;
  skt_res_t           res_r, res_nxt;
  logic               res_valid_r, res_valid_nxt;

  logic [DEPTH-1:0]   valid;
  logic [DEPTH-1:0]   ins_here;
  logic [DEPTH-1:0]   ge;
  logic [DEPTH-1:0]   eq;
  logic [DEPTH-1:0]   from_dn;
  logic signed [31:0] up_key [DEPTH];
  logic        [31:0] up_pay [DEPTH];
  logic signed [31:0] dn_key [DEPTH];
  logic        [31:0] dn_pay [DEPTH];
  logic               full;
  logic               found;
  logic               list_last;

  assign cnt_m1    = count_r - CNT_W'(1);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign list_last = ({1'b0, idx_r} == CNT_W'(cnt_m1));

  // per-cell compares against the request key
  always_comb begin
    for (int j = 0; j < DEPTH; j++) begin
      valid[j] = (CNT_W'(j) < count_r);
      ge[j]    = valid[j] && (key_r[j] >= req_r.req_key);
      eq[j]    = valid[j] && (key_r[j] == req_r.req_key);
      if (j == 0) begin
        ins_here[j] = !valid[j] || (key_r[j] > req_r.req_key);
      end else begin
        ins_here[j] = !valid[j] || ge[j];
      end
    end
    found = |eq;
  end

  // neighbour taps
  always_comb begin
    from_dn[0] = 1'b0;
    dn_key[0]  = req_r.req_key;
    dn_pay[0]  = req_r.req_payload;
    for (int j = 1; j < DEPTH; j++) begin
      from_dn[j] = ins_here[j-1];
      dn_key[j]  = key_r[j-1];
      dn_pay[j]  = pay_r[j-1];
    end
    for (int j = 0; j < DEPTH - 1; j++) begin
      up_key[j] = key_r[j+1];
      up_pay[j] = pay_r[j+1];
    end
    up_key[DEPTH-1] = key_r[DEPTH-1];
    up_pay[DEPTH-1] = pay_r[DEPTH-1];
  end

  // next cell contents
  always_comb begin
    for (int j = 0; j < DEPTH; j++) begin
      key_nxt[j] = key_r[j];
      pay_nxt[j] = pay_r[j];
      case (cmd.op)
        OP_INSERT: begin
          if (!full) begin
            if (from_dn[j]) begin
              key_nxt[j] = dn_key[j];
              pay_nxt[j] = dn_pay[j];
            end else if (ins_here[j]) begin
              key_nxt[j] = req_r.req_key;
              pay_nxt[j] = req_r.req_payload;
            end
          end
        end
        OP_REMOVE: begin
          if (found && ge[j]) begin
            key_nxt[j] = up_key[j];
            pay_nxt[j] = up_pay[j];
          end
        end
        OP_LIST: begin
          // rotate the valid part: tail takes the head
          if (CNT_W'(j) == cnt_m1) begin
            key_nxt[j] = key_r[0];
            pay_nxt[j] = pay_r[0];
          end else begin
            key_nxt[j] = up_key[j];
            pay_nxt[j] = up_pay[j];
          end
        end
        default: ;
      endcase
    end
  end

  // count, dump index and result
  always_comb begin
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    res_valid_nxt = 1'b1;
    res_nxt       = '0;
    res_nxt.last  = 1'b1;
    case (cmd.op)
      OP_INSERT: begin
        if (full) begin
          res_nxt.status = STS_FULL;
        end else begin
          count_nxt      = count_r + CNT_W'(1);
          res_nxt.status = STS_DONE;
        end
      end
      OP_REMOVE: begin
        if (found) begin
          count_nxt      = cnt_m1;
          res_nxt.status = STS_DONE;
        end else begin
          res_nxt.status = STS_NOT_FOUND;
        end
      end
      OP_EMPTY: res_nxt.status = STS_EMPTY;
      OP_LIST: begin
        res_nxt.status      = STS_LISTED;
        res_nxt.out_key     = key_r[0];
        res_nxt.out_payload = pay_r[0];
        res_nxt.last        = list_last;
        idx_nxt             = idx_r + IDX_W'(1);
      end
      OP_NOP: res_nxt.status = STS_DONE;
      default: res_valid_nxt = 1'b0;
    endcase
    if (cmd.load) idx_nxt = '0;
  end

  // cell chain, no reset needed
  always_ff @(posedge clk) begin
    for (int j = 0; j < DEPTH; j++) begin
      key_r[j] <= key_nxt[j];
      pay_r[j] <= pay_nxt[j];
    end
  end

  // request and result payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= in_req;
    res_r <= res_nxt;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      res_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  assign stat.req_type   = req_r.req_type;
  assign stat.count_zero = (count_r == '0);
  assign stat.list_last  = list_last;
  assign out_res         = res_r;
  assign out_valid       = res_valid_r;

endmodule

// ===== hw/rtl/sorted_key_table.sv =====
// ---------------------------------------------------------------------------
// sorted_key_table
// Table of up to DEPTH key/payload entries kept in ascending signed key
// order, with insert, remove by key and in-order dump requests.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Insert, remove and
// unused request types latch the request, then let the whole cell chain
// compare and shift, and give one registered result. A dump emits the head
// cell each cycle as the chain rotates once round, one result per stored
// entry, the final entry flagged with last; an empty table gives a single
// result with status empty.
// Results are shown for exactly one cycle on out_res with out_valid high; the
// receiver cannot stall them and must take each one as it appears. The next
// request may be started in the cycle in which a result is shown.
module sorted_key_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  skt_pkg::skt_req_t  in_req,
  output logic               busy,
  output skt_pkg::skt_res_t  out_res,
  output logic               out_valid
);
  import skt_pkg::*;

  skt_cmd_t  cmd;
  skt_stat_t stat;

  // request sequencer
  skt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // cell chain datapath
  skt_cells u_cells (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .stat      (stat),
    .out_res   (out_res),
    .out_valid (out_valid)
  );

endmodule
